// File: sv/tkpd_pkg.sv
// ----------------------------------------------------------------------------
// tkpd_pkg: shared types and constants of the tilt balance controller
// Holds the sequencer state codes, the configuration register indexes, the
// fixed Q30 filter constants and the rounding and saturation helpers.
// ----------------------------------------------------------------------------
package tkpd_pkg;

    localparam int MUL_W  = 34;
    localparam int PROD_W = 68;
    localparam int CFG_W  = 20;

    // Filter constants in Q30.
    localparam logic signed [MUL_W-1:0] K_DT      = 34'sd10737418;
    localparam logic signed [MUL_W-1:0] K_ALPHA   = 34'sd1052266988;
    localparam logic signed [MUL_W-1:0] K_ALPHA_C = 34'sd21474836;
    localparam longint K_QA_Q30   = 64'sd1073742;
    localparam longint K_QBDT_Q30 = 64'sd32212;
    localparam longint K_R_Q30    = 64'sd21474836;

    localparam logic signed [PROD_W-1:0] S32_MAX = 68'sd2147483647;
    localparam logic signed [PROD_W-1:0] S32_MIN = -68'sd2147483648;

    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_RESET  = 2'd1;
    localparam logic [1:0] MODE_FAIL   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [2:0] CFG_PROP_GAIN     = 3'd0;
    localparam logic [2:0] CFG_RATE_GAIN     = 3'd1;
    localparam logic [2:0] CFG_TARGET_TILT   = 3'd2;
    localparam logic [2:0] CFG_GYRO_ZERO     = 3'd3;
    localparam logic [2:0] CFG_FUSION_SELECT = 3'd4;
    localparam logic [2:0] CFG_DRIVE_INVERT  = 3'd5;
    localparam logic [2:0] CFG_LEFT_INVERT   = 3'd6;
    localparam logic [2:0] CFG_RIGHT_INVERT  = 3'd7;

    typedef enum logic [27:0] {
        ST_IDLE     = 28'd1 << 0,
        ST_DISP     = 28'd1 << 1,
        ST_KA_MUL   = 28'd1 << 2,
        ST_KA_TILT  = 28'd1 << 3,
        ST_KA_COV   = 28'd1 << 4,
        ST_KA_INNER = 28'd1 << 5,
        ST_KA_PAA   = 28'd1 << 6,
        ST_KA_DIV0  = 28'd1 << 7,
        ST_KA_WAIT0 = 28'd1 << 8,
        ST_KA_WAIT1 = 28'd1 << 9,
        ST_KA_M0    = 28'd1 << 10,
        ST_KA_U0    = 28'd1 << 11,
        ST_KA_U1    = 28'd1 << 12,
        ST_KA_U2    = 28'd1 << 13,
        ST_KA_U3    = 28'd1 << 14,
        ST_KA_U4    = 28'd1 << 15,
        ST_KA_U5    = 28'd1 << 16,
        ST_CF_MUL   = 28'd1 << 17,
        ST_CF_PRED  = 28'd1 << 18,
        ST_CF_MA    = 28'd1 << 19,
        ST_CF_MB    = 28'd1 << 20,
        ST_CF_SUM   = 28'd1 << 21,
        ST_PD_ERR   = 28'd1 << 22,
        ST_PD_KD    = 28'd1 << 23,
        ST_PD_RAW   = 28'd1 << 24,
        ST_PD_MAG   = 28'd1 << 25,
        ST_PD_PWM   = 28'd1 << 26,
        ST_FIN      = 28'd1 << 27
    } state_t;

    // Arithmetic right shift that rounds half away from zero.
    function automatic logic signed [PROD_W-1:0] rsr(input logic signed [PROD_W-1:0] v,
                                                     input int n);
        logic signed [PROD_W-1:0] half;
        logic signed [PROD_W-1:0] r;
        half = $signed((PROD_W'(1) << n) >> 1);
        if (v >= 0)
        begin
            r = (v + half) >>> n;
        end
        else
        begin
            r = -((-v + half) >>> n);
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < S32_MIN)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: sv/tkpd_div.sv
// ----------------------------------------------------------------------------
// tkpd_div: unsigned restoring divider
// Produces one quotient bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module tkpd_div #(
    parameter int NUM_W = 60,
    parameter int DEN_W = 33
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W+1:0] diff;
    logic             ge;

    assign rem_sh = {rem_reg, quo_reg[NUM_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, den_reg};
    assign ge     = ~diff[DEN_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: sv/tilt_kalman_pd_balance_controller.sv
// ----------------------------------------------------------------------------
// tilt_kalman_pd_balance_controller: tilt fusion and PD balance loop
// Kalman or complementary fusion of a pitch angle and a gyro rate, followed
// by a PD law and a PWM map with dead zone, jump, slope and limit.
// ----------------------------------------------------------------------------
// Usage. One input word per IMU sample arrives on the s_ channel: s_tuser
// carries the mode (sample, filter reset or failed read) and s_tdata the
// accelerometer angle and the raw gyro rate. For every accepted word exactly
// one result word leaves on the m_ channel with the fused angle, the corrected
// rate, the common and per-wheel PWM values and, in m_tuser, the fall flag.
// Configuration registers are written through cfg_we, cfg_index and cfg_data;
// the user must write them while the block is idle; the block does not enforce this.
// The filter and PD products run through one shared signed 34 x 34
// multiplier and the Kalman gain divisions through one bit-serial divider,
// all under a sequencer. A Kalman sample is dominated by the two gain
// divisions at one quotient bit per cycle; a tripped fall check skips four
// PD steps. s_tready is high only when the sequencer is idle, so the next
// word can be taken as soon as the result is posted. The result sits in an
// output register, so a new word is accepted while the previous result waits;
// if the receiver stalls, the next result is held in the last sequencer step
// until the output register frees up.
// Reset clears the filter state to zero and loads the register defaults.
// ----------------------------------------------------------------------------
module tilt_kalman_pd_balance_controller
    import tkpd_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int COV_FRAC_BITS   = 28
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [39:0]      s_tdata,   // accel_tilt[16:0], gyro_raw[36:17], zero fill
    input  logic [1:0]       s_tuser,   // mode[1:0]
    output logic             m_tvalid,
    input  logic             m_tready,
    // tilt_estimate[16:0], rate_corrected[37:17], drive_pwm[45:38],
    // left_pwm[53:46], right_pwm[61:54], zero fill
    output logic [63:0]      m_tdata,
    output logic             m_tuser,   // fallen[0]
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int     CSH      = 30 - COV_FRAC_BITS;
    localparam longint QA_COV   = (K_QA_Q30 + ((longint'(1) << CSH) >>> 1)) >>> CSH;
    localparam longint QBDT_COV = (K_QBDT_Q30 + ((longint'(1) << CSH) >>> 1)) >>> CSH;
    localparam longint R_COV    = (K_R_Q30 + ((longint'(1) << CSH) >>> 1)) >>> CSH;
    localparam int     SFRAC    = ANGLE_FRAC_BITS + 8;
    localparam int     PWM_FRAC = SFRAC + ANGLE_FRAC_BITS;
    localparam longint FALL_LIM = longint'(35) << SFRAC;
    localparam longint TILT_LIM = longint'(180) << ANGLE_FRAC_BITS;
    localparam longint PWM_FOUR = longint'(4) << PWM_FRAC;
    localparam longint PWM_FIVE = longint'(5) << PWM_FRAC;
    localparam int     NUM_W    = 32 + COV_FRAC_BITS;
    localparam int     DEN_W    = 33;

    // Configuration registers.
    logic        [15:0] prop_gain_reg;
    logic        [15:0] rate_gain_reg;
    logic signed [16:0] target_tilt_reg;
    logic signed [19:0] gyro_zero_reg;
    logic               fusion_select_reg;
    logic               drive_invert_reg;
    logic               left_invert_reg;
    logic               right_invert_reg;

    // Sequencer and filter state.
    state_t             state_reg;
    logic        [1:0]  mode_reg;
    logic signed [24:0] acc_s_reg;
    logic signed [20:0] rate_reg;
    logic signed [31:0] tilt_reg;
    logic signed [31:0] bias_reg;
    logic signed [31:0] cov_aa_reg;
    logic signed [31:0] cov_ab_reg;
    logic signed [31:0] cov_ba_reg;
    logic signed [31:0] cov_bb_reg;

    // Working registers.
    logic signed [31:0]       tmp_reg;
    logic signed [31:0]       y_reg;
    logic signed [31:0]       k0_reg;
    logic signed [31:0]       k1_reg;
    logic signed [MUL_W-1:0]  s_reg;
    logic                     div_neg_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] raw_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic        [8:0]        q_reg;
    logic                     small_reg;
    logic                     neg_reg;

    // Result staging and output register.
    logic signed [20:0] res_rate_reg;
    logic signed [7:0]  res_pwm_reg;
    logic signed [7:0]  res_left_reg;
    logic signed [7:0]  res_right_reg;
    logic               res_fall_reg;
    logic               m_tvalid_reg;
    logic        [63:0] m_tdata_reg;
    logic               m_tuser_reg;

    // Combinational helpers.
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [MUL_W-1:0]  rate_s_w;
    logic signed [MUL_W-1:0]  eff_w;
    logic signed [MUL_W-1:0]  target_s_w;
    logic signed [MUL_W-1:0]  err_w;
    logic signed [PROD_W-1:0] prod_r30;
    logic signed [PROD_W-1:0] prod_rc;
    logic signed [31:0]       inner_w;
    logic signed [MUL_W-1:0]  s_w;
    logic signed [31:0]       y_w;
    logic signed [PROD_W-1:0] tilt_rnd;
    logic signed [PROD_W-1:0] tilt_clamped;
    logic signed [PROD_W-1:0] raw_w;
    logic signed [PROD_W-1:0] mag_w;
    logic signed [PROD_W-1:0] x_w;
    logic signed [PROD_W-1:0] qq_w;
    logic        [16:0]       qm_w;
    logic        [6:0]        pwm_mag_w;
    logic signed [7:0]        pwm_w;
    logic signed [20:0]       rate_in_w;

    // Divider hookup.
    logic                     div_start;
    logic signed [31:0]       div_src;
    logic signed [MUL_W-1:0]  div_den_s;
    logic        [31:0]       div_src_abs;
    logic        [NUM_W-1:0]  div_num;
    logic        [DEN_W-1:0]  div_den;
    logic                     div_done;
    logic        [NUM_W-1:0]  div_quo;
    logic signed [31:0]       k_sat;

    logic s_fire;
    logic out_free;

    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    assign rate_in_w  = 21'(signed'(s_tdata[36:17])) - 21'(gyro_zero_reg);
    assign rate_s_w   = MUL_W'(rate_reg) <<< 8;
    assign eff_w      = rate_s_w - MUL_W'(bias_reg);
    assign target_s_w = MUL_W'(target_tilt_reg) <<< 8;
    assign err_w      = target_s_w - MUL_W'(tilt_reg);
    assign prod_r30   = rsr(prod_reg, 30);
    assign prod_rc    = rsr(prod_reg, COV_FRAC_BITS);
    assign inner_w    = sat32(prod_r30 - PROD_W'(cov_ab_reg) - PROD_W'(cov_ba_reg)
                              + PROD_W'(QA_COV));
    assign s_w        = MUL_W'(cov_aa_reg) + MUL_W'(R_COV);
    assign y_w        = sat32(PROD_W'(acc_s_reg) - PROD_W'(tilt_reg));

    // Reported angle: back to Q(A), clamped to plus or minus 180 degrees.
    assign tilt_rnd = rsr(PROD_W'(tilt_reg), 8);
    always_comb
    begin
        if (tilt_rnd > PROD_W'(TILT_LIM))
        begin
            tilt_clamped = PROD_W'(TILT_LIM);
        end
        else if (tilt_rnd < -PROD_W'(TILT_LIM))
        begin
            tilt_clamped = -PROD_W'(TILT_LIM);
        end
        else
        begin
            tilt_clamped = tilt_rnd;
        end
    end

    // PD output and PWM map.
    assign raw_w     = drive_invert_reg ? (prod_reg - acc_reg) : (acc_reg - prod_reg);
    assign mag_w     = raw_reg[PROD_W-1] ? -raw_reg : raw_reg;
    assign x_w       = ((mag_w - PROD_W'(PWM_FOUR)) <<< 3) + PROD_W'(PWM_FIVE);
    assign qq_w      = x_w >>> PWM_FRAC;
    assign qm_w      = 17'(q_reg) * 17'd205;
    assign pwm_mag_w = small_reg ? 7'd0 : 7'(7'd40 + 7'(qm_w >> 11));
    assign pwm_w     = neg_reg ? -8'(pwm_mag_w) : 8'(pwm_mag_w);

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_KA_MUL:
            begin
                mul_a = K_DT;
                mul_b = eff_w;
            end
            ST_KA_TILT:
            begin
                mul_a = K_DT;
                mul_b = MUL_W'(cov_bb_reg);
            end
            ST_KA_INNER:
            begin
                mul_a = K_DT;
                mul_b = MUL_W'(tmp_reg);
            end
            ST_KA_M0:
            begin
                mul_a = MUL_W'(k0_reg);
                mul_b = MUL_W'(y_reg);
            end
            ST_KA_U0:
            begin
                mul_a = MUL_W'(k1_reg);
                mul_b = MUL_W'(y_reg);
            end
            ST_KA_U1:
            begin
                mul_a = MUL_W'(k0_reg);
                mul_b = MUL_W'(cov_aa_reg);
            end
            ST_KA_U2:
            begin
                mul_a = MUL_W'(k1_reg);
                mul_b = MUL_W'(cov_aa_reg);
            end
            ST_KA_U3:
            begin
                mul_a = MUL_W'(k0_reg);
                mul_b = MUL_W'(cov_ab_reg);
            end
            ST_KA_U4:
            begin
                mul_a = MUL_W'(k1_reg);
                mul_b = MUL_W'(cov_ab_reg);
            end
            ST_CF_MUL:
            begin
                mul_a = K_DT;
                mul_b = rate_s_w;
            end
            ST_CF_MA:
            begin
                mul_a = K_ALPHA;
                mul_b = MUL_W'(tmp_reg);
            end
            ST_CF_MB:
            begin
                mul_a = K_ALPHA_C;
                mul_b = MUL_W'(acc_s_reg);
            end
            ST_PD_ERR:
            begin
                mul_a = MUL_W'({1'b0, prop_gain_reg});
                mul_b = err_w;
            end
            ST_PD_KD:
            begin
                mul_a = MUL_W'({1'b0, rate_gain_reg});
                mul_b = rate_s_w;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Kalman gain division: magnitudes go through the divider, sign is kept here.
    assign div_start   = (state_reg == ST_KA_DIV0 && s_w != '0) ||
                         (state_reg == ST_KA_WAIT0 && div_done);
    assign div_src     = (state_reg == ST_KA_DIV0) ? cov_aa_reg : cov_ba_reg;
    assign div_den_s   = (state_reg == ST_KA_DIV0) ? s_w : s_reg;
    assign div_src_abs = div_src[31] ? 32'(-div_src) : 32'(div_src);
    assign div_num     = NUM_W'(div_src_abs) << COV_FRAC_BITS;
    assign div_den     = div_den_s[MUL_W-1] ? DEN_W'(-div_den_s) : DEN_W'(div_den_s);

    always_comb
    begin
        if (div_neg_reg)
        begin
            if (div_quo >= NUM_W'(64'h80000000))
            begin
                k_sat = 32'sh80000000;
            end
            else
            begin
                k_sat = -$signed(div_quo[31:0]);
            end
        end
        else
        begin
            if (div_quo > NUM_W'(64'h7fffffff))
            begin
                k_sat = 32'sh7fffffff;
            end
            else
            begin
                k_sat = $signed(div_quo[31:0]);
            end
        end
    end

    tkpd_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= 16'd1024;
            rate_gain_reg     <= 16'd90;
            target_tilt_reg   <= 17'sd256;
            gyro_zero_reg     <= '0;
            fusion_select_reg <= 1'b0;
            drive_invert_reg  <= 1'b1;
            left_invert_reg   <= 1'b0;
            right_invert_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PROP_GAIN:     prop_gain_reg     <= cfg_data[15:0];
                CFG_RATE_GAIN:     rate_gain_reg     <= cfg_data[15:0];
                CFG_TARGET_TILT:   target_tilt_reg   <= signed'(cfg_data[16:0]);
                CFG_GYRO_ZERO:     gyro_zero_reg     <= signed'(cfg_data[19:0]);
                CFG_FUSION_SELECT: fusion_select_reg <= cfg_data[0];
                CFG_DRIVE_INVERT:  drive_invert_reg  <= cfg_data[0];
                CFG_LEFT_INVERT:   left_invert_reg   <= cfg_data[0];
                CFG_RIGHT_INVERT:  right_invert_reg  <= cfg_data[0];
                default:           prop_gain_reg     <= prop_gain_reg;
            endcase
        end
    end

    // Sequencer with filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tilt_reg     <= '0;
            bias_reg     <= '0;
            cov_aa_reg   <= '0;
            cov_ab_reg   <= '0;
            cov_ba_reg   <= '0;
            cov_bb_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // A finished result is posted when the output register is free.
            if (state_reg == ST_FIN && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        state_reg <= ST_DISP;
                    end
                end
                ST_DISP:
                begin
                    if (mode_reg == MODE_SAMPLE)
                    begin
                        state_reg <= fusion_select_reg ? ST_CF_MUL : ST_KA_MUL;
                    end
                    else if (mode_reg == MODE_RESET)
                    begin
                        // The filter restarts at the target with no bias or covariance.
                        tilt_reg   <= 32'(target_s_w);
                        bias_reg   <= '0;
                        cov_aa_reg <= '0;
                        cov_ab_reg <= '0;
                        cov_ba_reg <= '0;
                        cov_bb_reg <= '0;
                        state_reg  <= ST_FIN;
                    end
                    else
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_KA_MUL:
                begin
                    state_reg <= ST_KA_TILT;
                end
                ST_KA_TILT:
                begin
                    tilt_reg  <= sat32(PROD_W'(tilt_reg) + prod_r30);
                    state_reg <= ST_KA_COV;
                end
                ST_KA_COV:
                begin
                    cov_ab_reg <= sat32(PROD_W'(cov_ab_reg) - prod_r30);
                    cov_ba_reg <= sat32(PROD_W'(cov_ba_reg) - prod_r30);
                    cov_bb_reg <= sat32(PROD_W'(cov_bb_reg) + PROD_W'(QBDT_COV));
                    state_reg  <= ST_KA_INNER;
                end
                ST_KA_INNER:
                begin
                    state_reg <= ST_KA_PAA;
                end
                ST_KA_PAA:
                begin
                    cov_aa_reg <= sat32(PROD_W'(cov_aa_reg) + prod_r30);
                    state_reg  <= ST_KA_DIV0;
                end
                ST_KA_DIV0:
                begin
                    // With zero innovation variance only the prediction applies.
                    state_reg <= (s_w == '0) ? ST_PD_ERR : ST_KA_WAIT0;
                end
                ST_KA_WAIT0:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_KA_WAIT1;
                    end
                end
                ST_KA_WAIT1:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_KA_M0;
                    end
                end
                ST_KA_M0:
                begin
                    state_reg <= ST_KA_U0;
                end
                ST_KA_U0:
                begin
                    tilt_reg  <= sat32(PROD_W'(tilt_reg) + prod_rc);
                    state_reg <= ST_KA_U1;
                end
                ST_KA_U1:
                begin
                    bias_reg  <= sat32(PROD_W'(bias_reg) + prod_rc);
                    state_reg <= ST_KA_U2;
                end
                ST_KA_U2:
                begin
                    cov_aa_reg <= sat32(PROD_W'(cov_aa_reg) - prod_rc);
                    state_reg  <= ST_KA_U3;
                end
                ST_KA_U3:
                begin
                    cov_ba_reg <= sat32(PROD_W'(cov_ba_reg) - prod_rc);
                    state_reg  <= ST_KA_U4;
                end
                ST_KA_U4:
                begin
                    cov_ab_reg <= sat32(PROD_W'(cov_ab_reg) - prod_rc);
                    state_reg  <= ST_KA_U5;
                end
                ST_KA_U5:
                begin
                    cov_bb_reg <= sat32(PROD_W'(cov_bb_reg) - prod_rc);
                    state_reg  <= ST_PD_ERR;
                end
                ST_CF_MUL:
                begin
                    state_reg <= ST_CF_PRED;
                end
                ST_CF_PRED:
                begin
                    state_reg <= ST_CF_MA;
                end
                ST_CF_MA:
                begin
                    state_reg <= ST_CF_MB;
                end
                ST_CF_MB:
                begin
                    state_reg <= ST_CF_SUM;
                end
                ST_CF_SUM:
                begin
                    tilt_reg  <= sat32(rsr(acc_reg + prod_reg, 30));
                    state_reg <= ST_PD_ERR;
                end
                ST_PD_ERR:
                begin
                    if (err_w > MUL_W'(FALL_LIM) || err_w < -MUL_W'(FALL_LIM))
                    begin
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        state_reg <= ST_PD_KD;
                    end
                end
                ST_PD_KD:
                begin
                    state_reg <= ST_PD_RAW;
                end
                ST_PD_RAW:
                begin
                    state_reg <= ST_PD_MAG;
                end
                ST_PD_MAG:
                begin
                    state_reg <= ST_PD_PWM;
                end
                ST_PD_PWM:
                begin
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (s_fire)
        begin
            mode_reg  <= s_tuser;
            acc_s_reg <= 25'(signed'(s_tdata[16:0])) <<< 8;
            rate_reg  <= rate_in_w;
        end
        if (div_start)
        begin
            div_neg_reg <= div_src[31] ^ div_den_s[MUL_W-1];
        end
        case (state_reg)
            ST_DISP:
            begin
                res_rate_reg  <= (mode_reg == MODE_SAMPLE) ? rate_reg : 21'sd0;
                res_fall_reg  <= (mode_reg != MODE_SAMPLE) && (mode_reg != MODE_RESET);
                res_pwm_reg   <= '0;
                res_left_reg  <= '0;
                res_right_reg <= '0;
            end
            ST_KA_COV:
            begin
                tmp_reg <= inner_w;
            end
            ST_KA_DIV0:
            begin
                s_reg <= s_w;
                y_reg <= y_w;
            end
            ST_KA_WAIT0:
            begin
                if (div_done)
                begin
                    k0_reg <= k_sat;
                end
            end
            ST_KA_WAIT1:
            begin
                if (div_done)
                begin
                    k1_reg <= k_sat;
                end
            end
            ST_CF_PRED:
            begin
                tmp_reg <= sat32(PROD_W'(tilt_reg) + prod_r30);
            end
            ST_CF_MB:
            begin
                acc_reg <= prod_reg;
            end
            ST_PD_ERR:
            begin
                res_fall_reg <= (err_w > MUL_W'(FALL_LIM) || err_w < -MUL_W'(FALL_LIM));
            end
            ST_PD_KD:
            begin
                acc_reg <= prod_reg;
            end
            ST_PD_RAW:
            begin
                raw_reg <= raw_w;
            end
            ST_PD_MAG:
            begin
                neg_reg   <= raw_reg[PROD_W-1];
                small_reg <= (mag_w < PROD_W'(PWM_FOUR));
                // Quotients of 300 and above already reach the limit of 70.
                q_reg     <= (qq_w >= PROD_W'(300)) ? 9'd300 : qq_w[8:0];
            end
            ST_PD_PWM:
            begin
                res_pwm_reg   <= pwm_w;
                res_left_reg  <= left_invert_reg ? -pwm_w : pwm_w;
                res_right_reg <= right_invert_reg ? -pwm_w : pwm_w;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    m_tdata_reg <= {2'b00, res_right_reg, res_left_reg, res_pwm_reg,
                                    res_rate_reg, tilt_clamped[16:0]};
                    m_tuser_reg <= res_fall_reg;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: sv/tkpd_chk.sv
// ----------------------------------------------------------------------------
// tkpd_chk: port-level checks of the tilt balance controller
// Watches the stream ports and checks sequencing and the PWM result words.
// ----------------------------------------------------------------------------
module tkpd_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);

    // One word is worked on at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted again right after an accepted word");

    // A fall or a failed read stops every motor.
    a_fall_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[61:38] == 24'd0))
        else $error("motor PWM nonzero in a fallen word");

    // The common PWM stays within the limit.
    a_pwm_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[45:38]) <= 8'sd70 &&
                      $signed(m_tdata[45:38]) >= -8'sd70))
        else $error("drive PWM beyond limit");

    // Each wheel gets the common PWM or its negation.
    a_wheel_dir: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[53:46] == m_tdata[45:38] ||
                       m_tdata[53:46] == 8'(-m_tdata[45:38])) &&
                      (m_tdata[61:54] == m_tdata[45:38] ||
                       m_tdata[61:54] == 8'(-m_tdata[45:38]))))
        else $error("wheel PWM does not follow drive PWM");

endmodule

bind tilt_kalman_pd_balance_controller tkpd_chk u_tkpd_chk (.*);
